// ----- rtl/mf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants for the 3x3 median filter with replicated
// borders: pixel and window types, line store ports, result queue items.
// ----------------------------------------------------------------------------
package mf3_pkg;

  typedef logic [7:0] pixel_t;

  // one window column: rows above, middle and below the output position
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  // [0] is the leftmost column
  typedef col_t [2:0] win_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_pair_t;

  typedef struct packed {
    logic older;
    logic newer;
  } line_we_t;

  typedef struct packed {
    pixel_t pixel;
    logic   last;
  } result_t;

  // up to two results per item, a before b
  typedef struct packed {
    logic [1:0] n;
    result_t    a;
    result_t    b;
  } push_t;

  localparam int APB_DATA_W   = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_ADDR_LSB = 2;
  localparam int CFG_W        = 11;
  localparam int ROW_W        = 10;
  localparam int HEIGHT_LIMIT = 1024;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  localparam int RESULT_DEPTH = 4;
  localparam int RES_PTR_W    = 2;
  localparam int RES_CNT_W    = 3;

  // fill counter value at which the read data is primed
  localparam logic [2:0] FILL_DONE = 3'd4;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_sel_t;

endpackage

// ----- rtl/mf3_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_line_store
// The two row memories (row two above and row just above the incoming row).
// One write and one read address per cycle, registered read data, with
// write-to-read forwarding when both hit the same column.
// ----------------------------------------------------------------------------
module mf3_line_store import mf3_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic       clk,
  input  line_we_t   wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_pair_t wr_data,
  input  logic [AW-1:0] rd_addr,
  output line_pair_t rd_data
);

  pixel_t older_mem [DEPTH];
  pixel_t newer_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.older) begin
      older_mem[wr_addr] <= wr_data.older;
    end
    if (wr_en.newer) begin
      newer_mem[wr_addr] <= wr_data.newer;
    end
  end

  always_ff @(posedge clk) begin
    rd_data.older <= (wr_en.older && (wr_addr == rd_addr)) ? wr_data.older
                                                           : older_mem[rd_addr];
    rd_data.newer <= (wr_en.newer && (wr_addr == rd_addr)) ? wr_data.newer
                                                           : newer_mem[rd_addr];
  end

endmodule

// ----- rtl/mf3_median9.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median9
// Median of a 3x3 window: sort each column, then take the median of
// (max of lows, median of mids, min of highs).
// ----------------------------------------------------------------------------
module mf3_median9 import mf3_pkg::*; (
  input  win_t   win,
  output pixel_t median
);

  function automatic pixel_t min2(pixel_t a, pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t max2(pixel_t a, pixel_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pixel_t med3(pixel_t a, pixel_t b, pixel_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pixel_t lo [3];
  pixel_t md [3];
  pixel_t hi [3];
  pixel_t lo_max, md_med, hi_min;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo[i] = min2(min2(win[i].top, win[i].mid), win[i].bot);
      hi[i] = max2(max2(win[i].top, win[i].mid), win[i].bot);
      md[i] = med3(win[i].top, win[i].mid, win[i].bot);
    end
    lo_max = max2(max2(lo[0], lo[1]), lo[2]);
    hi_min = min2(min2(hi[0], hi[1]), hi[2]);
    md_med = med3(md[0], md[1], md[2]);
    median = med3(lo_max, md_med, hi_min);
  end

endmodule

// ----- rtl/mf3_result_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_result_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// The producer keeps count of free slots before it accepts an item.
// ----------------------------------------------------------------------------
module mf3_result_fifo import mf3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  push_t                push,
  input  logic                 out_ready,
  output logic                 out_valid,
  output result_t              out_data,
  output logic [RES_CNT_W-1:0] count
);

  result_t              slots [RESULT_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.a;
    end
    if (push.n == 2'd2) begin
      slots[wr_ptr + RES_PTR_W'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.n);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + RES_CNT_W'(push.n) - RES_CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/median_filter_3x3_replicate_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_replicate_top
// 3x3 median filter over a raster stream of 8-bit grey pixels, borders
// replicated. Output lags one row and one pixel; flush items drain the
// last row, and the final output of a frame is flagged.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | op (0 pixel, 1 flush), pixel_in[7:0]
//  out     | out_valid/out_ready| pixel_out[7:0], frame_last
//  cfg     | APB, pready tied 1 | 0x0 frame_width, 0x4 frame_height (11 bit)
//
//  One item per cycle while in_ready is high; each result passes the input
//  register stage, the median stage, then the result queue.
//  A row-end item gives two results, so the output port sets the pace there.
//  After reset or a config write the line-store read port re-primes before
//  input is taken; at frame end and after a config write during a drain the
//  flush window is reloaded through the same port.
//  Reset clears control state only; line memories are not cleared.
// ----------------------------------------------------------------------------
module median_filter_3x3_replicate_top import mf3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [7:0]            pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_out,
  output logic                  frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = CW + 1;
  localparam int XW = CW + 2;
  localparam int WW = (NW > CFG_W) ? NW : CFG_W;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_write;

  // position and drain state
  logic [CW-1:0]    column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [NW-1:0]    drain_count, drain_count_next;
  logic [2:0]       fill, fill_next;

  // effective sizes and positions
  logic [WW-1:0]    fw_ext;
  logic [NW-1:0]    w_eff;
  logic [CW-1:0]    w_last;
  logic [CFG_W-1:0] h_eff;
  logic [ROW_W-1:0] h_last;
  logic [CW-1:0]    col_eff;
  logic [ROW_W-1:0] row_eff;
  logic [NW-1:0]    drain_eff;
  logic             drain_active;
  logic [CW-1:0]    d_col;

  // handshake
  logic primed, credit_ok, accept, pixel_go, flush_go;

  // line store
  line_we_t   ls_we;
  line_pair_t ls_wdata;
  line_pair_t rd_data;
  logic [CW-1:0] rd_addr;
  logic [XW-1:0] fetch_base, fetch_pos;
  logic [2:0]    fetch_step;
  logic [CW-1:0] drain_addr, pixel_addr;

  // pixel window
  win_t   win, win_next, b_win;
  col_t   new_col;
  pixel_t top_px, mid_px;
  logic   emit_a, emit_b, row_last_col, frame_end;

  // flush window
  col_t lcol, ccol, rcol, load_col;
  logic shift_drain;

  // median stage input
  logic [1:0] job_n, job_n_next;
  logic       job_last, job_last_next;
  win_t       job_a, job_a_next, job_b, job_b_next;

  pixel_t               med_a, med_b;
  push_t                push;
  result_t              out_data;
  logic [RES_CNT_W-1:0] out_count;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel_t'(paddr[REG_ADDR_LSB]))
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
    endcase
  end

  // ------------------------------------------------------- effective sizes
  always_comb begin
    fw_ext = WW'(frame_width);
    if (frame_width == '0) begin
      w_eff = NW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = NW'(MAX_WIDTH);
    end else begin
      w_eff = NW'(fw_ext);
    end
    w_last = CW'(w_eff - NW'(1));

    if (frame_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (frame_height > CFG_W'(HEIGHT_LIMIT)) begin
      h_eff = CFG_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
    h_last = ROW_W'(h_eff - CFG_W'(1));

    // positions left beyond a shrunk frame wrap to zero
    col_eff      = (NW'(column_count) >= w_eff) ? '0 : column_count;
    row_eff      = (CFG_W'(row_count) >= h_eff) ? '0 : row_count;
    drain_eff    = (drain_count > w_eff) ? w_eff : drain_count;
    drain_active = (drain_eff != '0);
    d_col        = CW'(w_eff - drain_eff);
  end

  // ------------------------------------------------------------- handshake
  assign primed    = drain_active ? (fill == FILL_DONE) : (fill != '0);
  assign credit_ok = (({1'b0, out_count} + 4'(job_n)) <= 4'(RESULT_DEPTH - 2));
  assign in_ready  = primed && credit_ok;
  assign accept    = in_valid && in_ready;
  assign pixel_go  = accept && !op && !drain_active;
  assign flush_go  = accept && op && drain_active;

  // ---------------------------------------------------------- pixel window
  always_comb begin
    mid_px  = rd_data.newer;
    top_px  = (row_eff == ROW_W'(1)) ? rd_data.newer : rd_data.older;
    new_col = '{top: top_px, mid: mid_px, bot: pixel_in};
    if (col_eff == '0) begin
      win_next[0] = new_col;
      win_next[1] = new_col;
      win_next[2] = new_col;
    end else begin
      win_next[0] = win[1];
      win_next[1] = win[2];
      win_next[2] = new_col;
    end
    // right edge: rightmost column repeated
    b_win[0] = win_next[1];
    b_win[1] = win_next[2];
    b_win[2] = win_next[2];

    row_last_col = (col_eff == w_last);
    emit_a       = (col_eff != '0);
    emit_b       = row_last_col;
    frame_end    = row_last_col && (row_eff == h_last);
  end

  always_comb begin
    ls_we.newer    = pixel_go;
    ls_we.older    = pixel_go && (row_eff != '0);
    ls_wdata.older = mid_px;
    ls_wdata.newer = pixel_in;
  end

  // ------------------------------------------------------------ counters
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    drain_count_next  = drain_count;
    if (pixel_go) begin
      if (row_last_col) begin
        column_count_next = '0;
        if (row_eff == h_last) begin
          row_count_next   = '0;
          drain_count_next = w_eff;
        end else begin
          row_count_next = row_eff + ROW_W'(1);
        end
      end else begin
        column_count_next = col_eff + CW'(1);
      end
    end else if (flush_go) begin
      drain_count_next = drain_eff - NW'(1);
    end

    if (cfg_write || (pixel_go && frame_end)) begin
      fill_next = '0;
    end else if (fill != FILL_DONE) begin
      fill_next = fill + 3'd1;
    end else begin
      fill_next = fill;
    end
  end

  // ----------------------------------------------------- read address
  // Drain: fill steps fetch columns d-1, d, d+1, d+2; once primed the read
  // data always holds column d+2 (clamped) for the next shift.
  always_comb begin
    if (fill != FILL_DONE) begin
      fetch_step = fill;
    end else if (flush_go) begin
      fetch_step = 3'd4;
    end else begin
      fetch_step = 3'd3;
    end
    fetch_base = XW'(d_col) + XW'(fetch_step);
    fetch_pos  = (fetch_base == '0) ? '0 : fetch_base - XW'(1);
    drain_addr = (fetch_pos > XW'(w_last)) ? w_last : CW'(fetch_pos);
    pixel_addr = pixel_go ? column_count_next : col_eff;
    if (drain_active && !(flush_go && (drain_eff == NW'(1)))) begin
      rd_addr = drain_addr;
    end else begin
      rd_addr = pixel_addr;
    end
  end

  mf3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ls_we),
    .wr_addr (col_eff),
    .wr_data (ls_wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------- flush window
  always_comb begin
    load_col.top = (h_eff != CFG_W'(1)) ? rd_data.older : rd_data.newer;
    load_col.mid = rd_data.newer;
    load_col.bot = rd_data.newer;
    shift_drain  = drain_active &&
                   (((fill != '0) && (fill != FILL_DONE)) || flush_go);
  end

  // ------------------------------------------------------- median stage in
  always_comb begin
    job_n_next    = '0;
    job_last_next = 1'b0;
    job_a_next    = job_a;
    job_b_next    = job_b;
    if (pixel_go && (row_eff != '0)) begin
      job_n_next = 2'(emit_a) + 2'(emit_b);
      job_a_next = emit_a ? win_next : b_win;
      job_b_next = b_win;
    end else if (flush_go) begin
      job_n_next    = 2'd1;
      job_last_next = (drain_eff == NW'(1));
      job_a_next[0] = lcol;
      job_a_next[1] = ccol;
      job_a_next[2] = rcol;
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
      fill         <= '0;
      win          <= '0;
      job_n        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (reg_sel_t'(paddr[REG_ADDR_LSB]))
          REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        endcase
      end
      column_count <= column_count_next;
      row_count    <= row_count_next;
      drain_count  <= drain_count_next;
      fill         <= fill_next;
      if (pixel_go && (row_eff != '0)) begin
        win <= win_next;
      end
      job_n <= job_n_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_drain) begin
      lcol <= ccol;
      ccol <= rcol;
      rcol <= load_col;
    end
    job_last <= job_last_next;
    job_a    <= job_a_next;
    job_b    <= job_b_next;
  end

  // --------------------------------------------------------- median + out
  mf3_median9 u_med_a (
    .win    (job_a),
    .median (med_a)
  );

  mf3_median9 u_med_b (
    .win    (job_b),
    .median (med_b)
  );

  always_comb begin
    push.n       = job_n;
    push.a.pixel = med_a;
    push.a.last  = job_last;
    push.b.pixel = med_b;
    push.b.last  = 1'b0;
  end

  mf3_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .count     (out_count)
  );

  assign pixel_out  = out_data.pixel;
  assign frame_last = out_data.last;

  // ----------------------------------------------------------- assertions
  a_queue_credit: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, out_count} + 4'(job_n)) <= 4'(RESULT_DEPTH)))
    else $error("results in flight exceed queue depth");

  a_frame_end_drain: assert property (@(posedge clk) disable iff (rst)
    (pixel_go && frame_end) |=> ((fill == '0) && (drain_count == $past(w_eff))))
    else $error("frame end did not arm the drain");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (flush_go && (drain_eff == NW'(1))) |=> (drain_count == '0))
    else $error("drain did not finish on last flush");

endmodule
